[hdl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// Shared action and status codes and the per-cell command bundle for the
// positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Action codes on in_action
  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_REMOVE   = 3'd1;
  localparam logic [2:0] ACT_RETRIEVE = 3'd2;
  localparam logic [2:0] ACT_REPLACE  = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  // Result status codes on out_status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Width of a cell index; covers cell indices up to 63
  localparam int IDX_W = 6;

  // Broadcast command seen by every cell in the chain
  typedef struct packed {
    logic       ins;  // insert: load at pos, shift up above pos
    logic       rem;  // remove: shift down at and above pos
    logic       rep;  // replace: load at pos
    logic [4:0] pos;
  } pls_op_t;

endpackage

[hdl/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to CAPACITY entries addressed by position, built as a
// chain of slot cells that shift toward their neighbors on insert and remove.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries an action (insert, remove, retrieve,
// replace, clear), a position and a value, and produces exactly one result
// transaction with a status, the removed or retrieved value (zero otherwise)
// and the entry count after the action. The block takes one transaction per
// clock cycle while in_stall is low: every cell compares its own index with
// the position and loads from the input, its left neighbor or its right
// neighbor in the same cycle, and the retrieved entry is collected by an OR
// chain running through the cells. The result is registered and appears the
// cycle after acceptance. in_stall rises only while a result sits in the
// output register and the consumer stalls it, so with no back-pressure
// throughput is one transaction per cycle. Entry storage has no reset; only
// the entry count is cleared, and only entries below the count are ever read.
module positional_list_store #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_entry_count
);
  import pls_pkg::*;

  // Count width holds 0..CAPACITY; compare width also covers the position
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  logic                  accept;
  pls_op_t               op;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [CW-1:0]         cnt_res;
  logic [EW-1:0]         pos_ext;
  logic [EW-1:0]         cnt_ext;
  logic [EW-1:0]         res_cnt_ext;
  logic [1:0]            status;
  logic                  rd_ok;
  logic [DATA_WIDTH-1:0] val_masked;
  logic [63:0]           val_wide;
  logic [63:0]           rd_wide;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_chain  [CAPACITY+1];

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [1:0]            out_status_r;
  logic [31:0]           out_read_value_r;
  logic [4:0]            out_entry_count_r;

  // Hold input while a finished result is still waiting
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign val_wide   = 64'(in_value);
  assign val_masked = val_wide[DATA_WIDTH-1:0];
  assign pos_ext    = EW'(in_position);
  assign cnt_ext    = EW'(count_r);

  // Decode the action against the current count
  always_comb begin
    status  = ST_OK;
    rd_ok   = 1'b0;
    cnt_res = count_r;
    op      = '0;
    op.pos  = in_position;
    case (in_action)
      ACT_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (count_r == CW'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          op.ins  = accept;
          cnt_res = CW'(count_r + 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          op.rem  = accept;
          rd_ok   = 1'b1;
          cnt_res = CW'(count_r - 1'b1);
        end
      end
      ACT_RETRIEVE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      ACT_REPLACE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          op.rep = accept;
        end
      end
      ACT_CLEAR: begin
        cnt_res = '0;
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase
  end

  assign count_nxt = accept ? cnt_res : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Chain of slot cells; the read chain runs from the tail to the head
  assign rd_chain[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    pls_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .ins_value  (val_masked),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_in      (rd_chain[i+1]),
      .data       (cell_data[i]),
      .rd_out     (rd_chain[i])
    );
  end

  assign rd_wide     = 64'(rd_chain[0]);
  assign res_cnt_ext = EW'(cnt_res);

  // Output register: load on accept, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r      <= status;
      out_read_value_r  <= rd_ok ? rd_wide[31:0] : 32'd0;
      out_entry_count_r <= res_cnt_ext[4:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

endmodule

[hdl/pls_cell.sv]
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds one entry, loads from the input, its left or its
// right neighbor, and forwards its entry down the read chain when selected.
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  pls_pkg::pls_op_t      op,
  input  logic [DATA_WIDTH-1:0] ins_value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_out
);
  import pls_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [IDX_W-1:0]      pos_w;
  logic                  at_pos;
  logic                  above_pos;
  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  assign pos_w     = IDX_W'(op.pos);
  assign at_pos    = (pos_w == MY_IDX);
  assign above_pos = (MY_IDX > pos_w);

  always_comb begin
    data_nxt = data_r;
    if (op.ins) begin
      if (at_pos) begin
        data_nxt = ins_value;
      end else if (above_pos) begin
        data_nxt = left_data;
      end
    end else if (op.rem) begin
      if (at_pos || above_pos) begin
        data_nxt = right_data;
      end
    end else if (op.rep && at_pos) begin
      data_nxt = ins_value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data   = data_r;
  // OR the selected entry into the read chain
  assign rd_out = rd_in | (at_pos ? data_r : '0);

endmodule

[hdl/pls_check.sv]
// ----------------------------------------------------------------------------
// pls_check
// Port-level checks for the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
module pls_check #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_read_value,
  input logic [4:0]  out_entry_count
);
  import pls_pkg::*;

  // Input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // A full status means the list is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == 5'(CAPACITY)))
    else $error("full status with count below capacity");

  // Failed actions return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == 32'd0))
    else $error("failed action returned data");

  // Accepted input yields a result in the next cycle
  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_read_value) && $stable(out_entry_count)))
    else $error("stalled result changed");

endmodule

bind positional_list_store pls_check #(
  .CAPACITY (CAPACITY)
) u_pls_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_read_value  (out_read_value),
  .out_entry_count (out_entry_count)
);

[tb/list_action_checker.sv]
// ----------------------------------------------------------------------------
// list_action_checker
// Watches both channels of the positional list store, keeps its own copy of
// the list, predicts the result of every accepted transaction and compares
// each accepted result against the oldest prediction still awaited.
// ----------------------------------------------------------------------------
module list_action_checker #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_read_value,
  input  logic [4:0]  out_entry_count,
  output int          mismatch_count,
  output int          awaited_count,
  output int          results_seen,
  output int          range_seen,
  output int          full_seen
);
  import pls_pkg::*;

  localparam logic [31:0] DATA_MASK = 32'hFFFF_FFFF >> (32 - DATA_WIDTH);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  entry_count;
  } list_answer_t;

  logic [31:0]  cells [CAPACITY];
  int           live_count;
  list_answer_t awaited_results[$];
  list_answer_t oldest;

  // Apply one action to the local list and return the answer it must give.
  function automatic list_answer_t apply_list_action(input logic [2:0] act,
                                                     input logic [4:0] pos_bits,
                                                     input logic [31:0] val);
    list_answer_t ans;
    int           pos;
    ans        = '0;
    ans.status = ST_OK;
    pos        = int'(pos_bits);
    case (act)
      ACT_INSERT: begin
        if (pos > live_count) begin
          ans.status = ST_RANGE;
        end else if (live_count >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = live_count; i > pos; i--) cells[i] = cells[i - 1];
          cells[pos] = val & DATA_MASK;
          live_count++;
        end
      end
      ACT_REMOVE: begin
        if (pos >= live_count) begin
          ans.status = ST_RANGE;
        end else begin
          ans.read_value = cells[pos];
          for (int i = pos; i + 1 < live_count; i++) cells[i] = cells[i + 1];
          live_count--;
        end
      end
      ACT_RETRIEVE: begin
        if (pos >= live_count) ans.status = ST_RANGE;
        else ans.read_value = cells[pos];
      end
      ACT_REPLACE: begin
        if (pos >= live_count) ans.status = ST_RANGE;
        else cells[pos] = val & DATA_MASK;
      end
      ACT_CLEAR: begin
        live_count = 0;
      end
      default: begin
      end
    endcase
    ans.entry_count = live_count[4:0];
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch on result %0d: %s got %h, want %h",
               results_seen, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      live_count     = 0;
      awaited_results.delete();
      mismatch_count = 0;
      results_seen   = 0;
      range_seen     = 0;
      full_seen      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited, status", 32'(out_status), 32'd0);
        end else begin
          oldest = awaited_results.pop_front();
          if (out_status !== oldest.status)
            report_mismatch("status", 32'(out_status), 32'(oldest.status));
          if (out_read_value !== oldest.read_value)
            report_mismatch("read_value", out_read_value, oldest.read_value);
          if (out_entry_count !== oldest.entry_count)
            report_mismatch("entry_count", 32'(out_entry_count), 32'(oldest.entry_count));
          if (oldest.status == ST_RANGE) range_seen++;
          if (oldest.status == ST_FULL) full_seen++;
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_list_action(in_action, in_position, in_value));
    end
    awaited_count = awaited_results.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list store with a directed walk through empty, full
// and out-of-range cases, then with random bursts of list actions that swing
// the list between empty and full, under random sender gaps and receiver
// stalls. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import pls_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int ITEM_TARGET = 1150;
  // Slowest pass: ~1200 transactions, each behind a long stall run and a gap.
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = ACT_RETRIEVE;
  logic [4:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [4:0]  out_entry_count;

  int mismatch_count;
  int awaited_count;
  int results_seen;
  int range_seen;
  int full_seen;

  int cycle_count = 0;
  int actions_sent = 0;   // transactions with a defined action code
  int ignored_sent = 0;   // transactions with an unused action code
  int shadow_count = 0;   // rough list fill, used only to steer positions
  bit growing = 1'b1;

  positional_list_store #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count)
  );

  list_action_checker #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .results_seen   (results_seen),
    .range_seen     (range_seen),
    .full_seen      (full_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run; the limit is far beyond the slowest correct pass.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: switch between free flow, light random stall and heavy stall
  // runs, each lasting a random number of cycles.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 60);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  // Present one transaction and hold it until the block takes it. Check the
  // stall at the falling edge so the decision never races the rising edge.
  // Return at the rising edge where the transaction was accepted.
  task automatic send_action(input logic [2:0] act, input logic [4:0] pos,
                             input logic [31:0] val);
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    // Track the fill roughly so random positions land in range most of the time.
    case (act)
      ACT_INSERT: if (pos <= shadow_count && shadow_count < CAPACITY) shadow_count++;
      ACT_REMOVE: if (pos < shadow_count) shadow_count--;
      ACT_CLEAR:  shadow_count = 0;
      default: begin
      end
    endcase
    if (act <= ACT_CLEAR) actions_sent++;
    else ignored_sent++;
  endtask

  // Drop valid for a random gap.
  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every awaited result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Pick one random transaction. The mix leans toward insert while growing
  // and toward remove while shrinking so the list keeps swinging between
  // empty and full; most positions fall in range, the rest anywhere.
  task automatic send_random_action();
    int          roll;
    int          ins_w;
    int          rem_w;
    logic [2:0]  act;
    logic [4:0]  pos;
    logic [31:0] val;
    if (shadow_count == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (shadow_count == 0) growing = 1'b1;
    if ($urandom_range(0, 49) == 0) growing = ~growing;
    ins_w = growing ? 55 : 15;
    rem_w = growing ? 15 : 55;
    roll  = $urandom_range(0, 99);
    if (roll < ins_w) act = ACT_INSERT;
    else if (roll < ins_w + rem_w) act = ACT_REMOVE;
    else if (roll < 80) act = ACT_RETRIEVE;
    else if (roll < 95) act = ACT_REPLACE;
    else if (roll < 96) act = ACT_CLEAR;
    else act = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 99) < 15) begin
      pos = 5'($urandom_range(0, 31));
    end else if (act == ACT_INSERT) begin
      pos = 5'($urandom_range(0, shadow_count));
    end else begin
      pos = (shadow_count == 0) ? 5'd0 : 5'($urandom_range(0, shadow_count - 1));
    end
    case ($urandom_range(0, 19))
      0:       val = 32'h0000_0000;
      1:       val = 32'hFFFF_FFFF;
      default: val = $urandom();
    endcase
    send_action(act, pos, val);
  endtask

  initial begin
    int burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every action but clear on the empty list, unused codes, fill to full,
    // inserts on the full list, then edge removes and a clear.
    send_action(ACT_REMOVE,   5'd0,  32'h1111_1111);
    send_action(ACT_RETRIEVE, 5'd0,  32'h0);
    send_action(ACT_REPLACE,  5'd0,  32'hFFFF_FFFF);
    send_action(ACT_INSERT,   5'd1,  32'h2222_2222);   // past the end
    send_action(3'd5,         5'd31, 32'hFFFF_FFFF);   // unused code
    send_action(3'd7,         5'd0,  32'h0);           // unused code
    send_action(ACT_INSERT,   5'd0,  32'h0000_0000);
    send_action(ACT_INSERT,   5'd1,  32'hFFFF_FFFF);
    for (int i = 2; i < CAPACITY; i++) begin
      case (i % 3)
        0:       send_action(ACT_INSERT, 5'd0, $urandom());
        1:       send_action(ACT_INSERT, 5'(i), $urandom());
        default: send_action(ACT_INSERT, 5'(i / 2), $urandom());
      endcase
    end
    send_action(ACT_INSERT,   5'd16, 32'hA5A5_A5A5);   // full, valid position
    send_action(ACT_INSERT,   5'd17, 32'h5A5A_5A5A);   // range wins over full
    send_action(ACT_RETRIEVE, 5'd15, 32'h0);
    send_action(ACT_REPLACE,  5'd15, 32'hFFFF_FFFF);
    send_action(ACT_REMOVE,   5'd0,  32'h0);           // head
    send_action(ACT_REMOVE,   5'd14, 32'h0);           // tail
    send_action(ACT_RETRIEVE, 5'd31, 32'h0);
    send_action(ACT_CLEAR,    5'd31, 32'hFFFF_FFFF);
    drain_results();

    // Random bursts with gaps, some back to back, and an occasional full drain.
    while (actions_sent < ITEM_TARGET) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_random_action();
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("drove %0d list actions and %0d unused codes in %0d cycles",
             actions_sent, ignored_sent, cycle_count);
    $display("checked %0d results: %0d out of range, %0d list full, %0d mismatches",
             results_seen, range_seen, full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pls_pkg.sv
hdl/pls_cell.sv
hdl/positional_list_store.sv
hdl/pls_check.sv
tb/list_action_checker.sv
tb/testbench.sv
